[rtl/core/led_matrix_two_wire_refresher_unit_assert.svh]
// ---------------------------------------------------------------------------
// led matrix refresher assertion macros
// concurrent checks on aclk, with or without the reset guard
// ---------------------------------------------------------------------------
`ifndef LED_MATRIX_TWO_WIRE_REFRESHER_UNIT_ASSERT_SVH
`define LED_MATRIX_TWO_WIRE_REFRESHER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked outside reset only
`define LMR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked at every edge, reset included
`define LMR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define LMR_ASSERT(label, prop, msg)
`define LMR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[rtl/core/lmr_pkg.sv]
// ---------------------------------------------------------------------------
// lmr_pkg
// shared types and command bytes of the led matrix refresher
// ---------------------------------------------------------------------------
`default_nettype none

package lmr_pkg;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_PIXEL   = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_REFRESH = 2'd3
    } lmr_kind_t;

    typedef enum logic [2:0] {
        SEQ_IDLE  = 3'd0,
        SEQ_START = 3'd1,
        SEQ_BIT   = 3'd2,
        SEQ_TAIL  = 3'd3,
        SEQ_STOP  = 3'd4
    } lmr_step_t;

    // classified request handed from front to back
    typedef struct packed {
        lmr_kind_t  kind;
        logic       in_range;
        logic [7:0] mask;
        logic [3:0] col;
        logic       on;
    } lmr_item_t;

    typedef struct packed {
        logic accepted;
        logic busy_res;
        logic data_pin;
        logic clock_pin;
    } lmr_result_t;

    localparam logic [7:0] CMD_DATA = 8'h40;
    localparam logic [7:0] CMD_ADDR = 8'hC0;
    localparam logic [7:0] CMD_CTRL = 8'h88;

    localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

[rtl/core/lmr_front.sv]
// ---------------------------------------------------------------------------
// lmr_front
// input register that classifies each request and precomputes the pixel mask
// ---------------------------------------------------------------------------
`default_nettype none

module lmr_front #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 8
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire [1:0]          in_op,
    input  wire [2:0]          in_row,
    input  wire [3:0]          in_col,
    input  wire                in_on,
    output logic               out_valid,
    input  wire                out_ready,
    output lmr_pkg::lmr_item_t out_item
);
    import lmr_pkg::*;

    logic      valid_reg;
    lmr_item_t item_reg;
    lmr_item_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        item_next.kind     = lmr_kind_t'(in_op);
        item_next.in_range = ({1'b0, in_row} < 4'(ROWS)) && ({1'b0, in_col} < 5'(COLUMNS));
        item_next.mask     = 8'(1) << in_row;
        item_next.col      = in_col;
        item_next.on       = in_on;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/lmr_queue.sv]
// ---------------------------------------------------------------------------
// lmr_queue
// short fifo between classifier and sequencer
// ---------------------------------------------------------------------------
`default_nettype none

module lmr_queue (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                push_valid,
    output logic               push_ready,
    input  lmr_pkg::lmr_item_t push_item,
    output logic               pop_valid,
    input  wire                pop_ready,
    output lmr_pkg::lmr_item_t pop_item
);
    import lmr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    lmr_item_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[rtl/core/lmr_back.sv]
// ---------------------------------------------------------------------------
// lmr_back
// frame buffer, two-wire slot sequencer and result register
// ---------------------------------------------------------------------------
`default_nettype none
`include "led_matrix_two_wire_refresher_unit_assert.svh"

module lmr_back #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 8
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_wr_en,
    input  wire [2:0]            cfg_wr_data,
    input  wire                  item_valid,
    output logic                 item_ready,
    input  lmr_pkg::lmr_item_t   item,
    output logic                 res_valid,
    input  wire                  res_ready,
    output lmr_pkg::lmr_result_t res
);
    import lmr_pkg::*;

    localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    logic [ROWS-1:0] fb_reg  [COLUMNS];
    logic [ROWS-1:0] fb_next [COLUMNS];

    lmr_step_t   step_reg,     step_next;
    logic [1:0]  frame_reg,    frame_next;
    logic [4:0]  byte_reg,     byte_next;
    logic [2:0]  bit_reg,      bit_next;
    logic [1:0]  phase_reg,    phase_next;
    logic [7:0]  shift_reg,    shift_next;
    logic        clk_lvl_reg,  clk_lvl_next;
    logic        dat_lvl_reg,  dat_lvl_next;
    logic [2:0]  bright_reg;
    logic        out_valid_reg, out_valid_next;
    lmr_result_t out_reg,      out_next;

    logic        pop;
    logic        busy;
    logic        ok;
    logic [4:0]  fetch_sel;
    logic [4:0]  col_sel;
    logic [4:0]  frame_bytes;
    logic [7:0]  fetch_byte;

    assign item_ready = !out_valid_reg || res_ready;
    assign pop        = item_valid && item_ready;
    assign busy       = step_reg != SEQ_IDLE;
    assign res_valid  = out_valid_reg;
    assign res        = out_reg;

    // byte that the next load picks up: index 0 in a start slot, else the following byte
    always_comb begin
        fetch_sel   = (step_reg == SEQ_START) ? 5'd0 : byte_reg + 5'd1;
        col_sel     = fetch_sel - 5'd1;
        frame_bytes = (frame_reg == 2'd1) ? 5'(COLUMNS + 1) : 5'd1;
        priority if (frame_reg == 2'd0) begin
            fetch_byte = CMD_DATA;
        end else if (frame_reg == 2'd2) begin
            fetch_byte = CMD_CTRL | {5'b0, bright_reg};
        end else if (fetch_sel == 5'd0) begin
            fetch_byte = CMD_ADDR;
        end else if (col_sel < 5'(COLUMNS)) begin
            fetch_byte = 8'(fb_reg[col_sel[IDX_W-1:0]]);
        end else begin
            fetch_byte = 8'h00;
        end
    end

    always_comb begin
        fb_next      = fb_reg;
        step_next    = step_reg;
        frame_next   = frame_reg;
        byte_next    = byte_reg;
        bit_next     = bit_reg;
        phase_next   = phase_reg;
        shift_next   = shift_reg;
        clk_lvl_next = clk_lvl_reg;
        dat_lvl_next = dat_lvl_reg;
        ok           = 1'b1;

        if (pop) begin
            unique case (item.kind)
                KIND_TICK: begin
                    unique case (step_reg)
                        SEQ_START: begin
                            unique case (phase_reg)
                                2'd0: begin
                                    dat_lvl_next = 1'b1;
                                    clk_lvl_next = 1'b1;
                                    phase_next   = 2'd1;
                                end
                                2'd1: begin
                                    dat_lvl_next = 1'b0;
                                    phase_next   = 2'd2;
                                end
                                default: begin
                                    clk_lvl_next = 1'b0;
                                    byte_next    = 5'd0;
                                    shift_next   = fetch_byte;
                                    bit_next     = 3'd0;
                                    phase_next   = 2'd0;
                                    step_next    = SEQ_BIT;
                                end
                            endcase
                        end
                        SEQ_BIT: begin
                            unique case (phase_reg)
                                2'd0: begin
                                    clk_lvl_next = 1'b0;
                                    phase_next   = 2'd1;
                                end
                                2'd1: begin
                                    dat_lvl_next = shift_reg[0];
                                    phase_next   = 2'd2;
                                end
                                default: begin
                                    clk_lvl_next = 1'b1;
                                    shift_next   = shift_reg >> 1;
                                    phase_next   = 2'd0;
                                    if (bit_reg == 3'd7) begin
                                        step_next = SEQ_TAIL;
                                    end else begin
                                        bit_next = bit_reg + 3'd1;
                                    end
                                end
                            endcase
                        end
                        SEQ_TAIL: begin
                            clk_lvl_next = 1'b0;
                            byte_next    = fetch_sel;
                            if (fetch_sel < frame_bytes) begin
                                shift_next = fetch_byte;
                                bit_next   = 3'd0;
                                phase_next = 2'd0;
                                step_next  = SEQ_BIT;
                            end else begin
                                step_next  = SEQ_STOP;
                                phase_next = 2'd0;
                            end
                        end
                        SEQ_STOP: begin
                            unique case (phase_reg)
                                2'd0: begin
                                    clk_lvl_next = 1'b0;
                                    phase_next   = 2'd1;
                                end
                                2'd1: begin
                                    dat_lvl_next = 1'b0;
                                    phase_next   = 2'd2;
                                end
                                2'd2: begin
                                    clk_lvl_next = 1'b1;
                                    phase_next   = 2'd3;
                                end
                                default: begin
                                    dat_lvl_next = 1'b1;
                                    phase_next   = 2'd0;
                                    byte_next    = 5'd0;
                                    bit_next     = 3'd0;
                                    if (frame_reg == 2'd2) begin
                                        frame_next = 2'd0;
                                        step_next  = SEQ_IDLE;
                                    end else begin
                                        frame_next = frame_reg + 2'd1;
                                        step_next  = SEQ_START;
                                    end
                                end
                            endcase
                        end
                        default: begin
                            // tick while idle leaves everything alone
                            step_next = SEQ_IDLE;
                        end
                    endcase
                end
                KIND_PIXEL: begin
                    if (busy) begin
                        ok = 1'b0;
                    end else if (item.in_range) begin
                        if (item.on) begin
                            fb_next[item.col[IDX_W-1:0]] =
                                fb_reg[item.col[IDX_W-1:0]] | item.mask[ROWS-1:0];
                        end else begin
                            fb_next[item.col[IDX_W-1:0]] =
                                fb_reg[item.col[IDX_W-1:0]] & ~item.mask[ROWS-1:0];
                        end
                    end
                end
                KIND_CLEAR: begin
                    if (busy) begin
                        ok = 1'b0;
                    end else begin
                        for (int i = 0; i < COLUMNS; i++) begin
                            fb_next[i] = '0;
                        end
                    end
                end
                default: begin
                    if (busy) begin
                        ok = 1'b0;
                    end else begin
                        step_next  = SEQ_START;
                        frame_next = 2'd0;
                        byte_next  = 5'd0;
                        bit_next   = 3'd0;
                        phase_next = 2'd0;
                    end
                end
            endcase
        end

        out_valid_next = pop || (out_valid_reg && !res_ready);
        if (pop) begin
            out_next.clock_pin = clk_lvl_next;
            out_next.data_pin  = dat_lvl_next;
            out_next.busy_res  = step_next != SEQ_IDLE;
            out_next.accepted  = ok;
        end else begin
            out_next = out_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= SEQ_IDLE;
            frame_reg     <= 2'd0;
            byte_reg      <= 5'd0;
            bit_reg       <= 3'd0;
            phase_reg     <= 2'd0;
            shift_reg     <= 8'h00;
            clk_lvl_reg   <= 1'b1;
            dat_lvl_reg   <= 1'b1;
            bright_reg    <= 3'd7;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < COLUMNS; i++) begin
                fb_reg[i] <= '0;
            end
        end else begin
            step_reg      <= step_next;
            frame_reg     <= frame_next;
            byte_reg      <= byte_next;
            bit_reg       <= bit_next;
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            clk_lvl_reg   <= clk_lvl_next;
            dat_lvl_reg   <= dat_lvl_next;
            out_valid_reg <= out_valid_next;
            fb_reg        <= fb_next;
            if (cfg_wr_en) begin
                bright_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    `LMR_ASSERT(busy_matches_seq, pop |=> (res.busy_res == (step_reg != SEQ_IDLE)), "busy flag disagrees with sequencer")
    `LMR_ASSERT(reject_while_busy, (pop && busy && item.kind != KIND_TICK) |=> !res.accepted, "command taken during refresh")
    `LMR_ASSERT(idle_lines_high, (step_reg == SEQ_IDLE) |-> (clk_lvl_reg && dat_lvl_reg), "lines not released while idle")
    `LMR_ASSERT_ALWAYS(bit_phase_range, (step_reg == SEQ_BIT) |-> (phase_reg != 2'd3), "bit slot phase out of range")

endmodule

`default_nettype wire

[rtl/core/led_matrix_two_wire_refresher_unit.sv]
// ---------------------------------------------------------------------------
// led_matrix_two_wire_refresher_unit
// frame buffer and slot-by-slot refresh driver for a two-wire led matrix
// ---------------------------------------------------------------------------
// usage:
//   s_ channel carries one request per handshake: s_tuser holds the op
//   (tick, pixel write, clear, start refresh), s_tdata the pixel fields.
//   every request yields exactly one result on the m_ channel with the
//   clock and data line levels, the busy flag and the accepted flag.
//   a refresh sends three frames; each tick request advances one slot,
//   496 ticks for the whole refresh at 16 columns.
//   a request passes the input register, the queue and the sequencer result
//   register on its way to the result. one request per cycle is sustained
//   while m_tready is high; the sequencer and frame buffer update once per request.
//   when m_tready is low the result register holds, the two-entry queue and
//   the input register fill, and s_tready drops after three requests wait.
//   reset clears the frame buffer, returns the sequencer to idle with both
//   lines high and sets brightness to 7. cfg_wr_en writes brightness and
//   should only be used while no request is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module led_matrix_two_wire_refresher_unit #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 8
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_wr_en,
    input  wire [2:0]  cfg_wr_data,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [7:0]  s_tdata,   // pixel_row[2:0], pixel_col[6:3], pixel_on[7]
    input  wire [1:0]  s_tuser,   // op[1:0]
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata    // clock_pin[0], data_pin[1], busy_res[2], accepted[3], zero[7:4]
);
    import lmr_pkg::*;

    logic        front_valid;
    logic        queue_ready;
    lmr_item_t   front_item;
    logic        queue_valid;
    logic        back_ready;
    lmr_item_t   queue_item;
    lmr_result_t back_res;

    lmr_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_row    (s_tdata[2:0]),
        .in_col    (s_tdata[6:3]),
        .in_on     (s_tdata[7]),
        .out_valid (front_valid),
        .out_ready (queue_ready),
        .out_item  (front_item)
    );

    lmr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (queue_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (back_ready),
        .pop_item   (queue_item)
    );

    lmr_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (queue_valid),
        .item_ready  (back_ready),
        .item        (queue_item),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (back_res)
    );

    assign m_tdata = {4'b0000, back_res.accepted, back_res.busy_res,
                      back_res.data_pin, back_res.clock_pin};

endmodule

`default_nettype wire
